@@ hw/rtl/cre_pkg.sv @@
package cre_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int MAX_PAIRS     = 6;
    localparam int NUM_RANGES    = 6;
    localparam int OUT_LIMIT     = LINE_CAPACITY - 1;

    localparam int CHAR_W     = 8;
    localparam int COL_W      = 6;
    localparam int RANGE_W    = 2 * COL_W;
    localparam int PCNT_W     = 3;
    localparam int TAIL_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RANGE_W;
    localparam int ADDR_W     = $clog2(LINE_CAPACITY);
    localparam int LEN_W      = $clog2(LINE_CAPACITY + 1);
    localparam int CNT_W      = $clog2(LINE_CAPACITY);
    localparam int IDX_W      = $clog2(NUM_RANGES + 1);

    localparam logic [TAIL_W-1:0] NO_TAIL = TAIL_W'(64);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_5     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_COLUMN = 3'd7;

    typedef struct packed {
        logic [PCNT_W-1:0]                   pair_count;
        logic [NUM_RANGES-1:0][RANGE_W-1:0] ranges;
        logic [TAIL_W-1:0]                   tail_column;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RANGE,
        ST_READ,
        ST_DATA,
        ST_CLOSE
    } t_state;

endpackage

@@ hw/rtl/cre_in_if.sv @@
interface cre_in_if import cre_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              line_done;

    modport source (output valid, in_char, line_done, input ready);
    modport sink   (input valid, in_char, line_done, output ready);
endinterface

@@ hw/rtl/cre_out_if.sv @@
interface cre_out_if import cre_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              last;

    modport source (output valid, out_char, char_valid, last, input ready);
    modport sink   (input valid, out_char, char_valid, last, output ready);
endinterface

@@ hw/rtl/column_range_extractor.sv @@
// channel   dir  modport  payload                       beat when
// i_in      in   sink     in_char[7:0], line_done       i_in.valid && i_in.ready
// o_out     out  source   out_char[7:0], char_valid,    o_out.valid && o_out.ready
//                         last
// cfg       in   -        i_cfg_index[2:0],             i_cfg_we
//                         i_cfg_data[11:0]
//
// while loading, character beats are taken one per cycle into the line store
// an end-of-line beat starts the walk: a lookup for each range, then for each
// emitted character a store read and then an output register load, which waits
// for a free output register; the read-then-emit loop on the line store is
// unpipelined, so a character is read only once the one before it is loaded
// into the output register; no input beat is taken during the walk; the closing beat is parked in the
// output register and loading of the next line resumes behind it
// reset (i_rst_n low, synchronous) empties the line and restores the register
// defaults; the line store needs no clearing, it is only read below the length
module column_range_extractor import cre_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cre_in_if.sink                i_in,
    cre_out_if.source             o_out
);

    // live register values; write only while no line is in flight (not enforced here)
    t_cfg cfg;

    // line store access from the walker
    t_ram_req          ram_req;
    logic [CHAR_W-1:0] ram_rdata;

    cre_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // one write port for loading, one registered read port for the walk
    cre_line_store u_line_store (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // sequencer: load, range lookup, read/emit loop, closing beat
    cre_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_req   (ram_req),
        .i_rdata (ram_rdata)
    );

endmodule

@@ hw/rtl/cre_cfg_regs.sv @@
module cre_cfg_regs import cre_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    logic [CFG_IDX_W-1:0] range_sel;

    assign range_sel = i_cfg_index - REG_RANGE_0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pair_count  <= '0;
            r_cfg.ranges      <= '0;
            r_cfg.tail_column <= NO_TAIL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                REG_PAIR_COUNT: begin
                    r_cfg.pair_count <= i_cfg_data[PCNT_W-1:0];
                end
                [REG_RANGE_0:REG_RANGE_5]: begin
                    r_cfg.ranges[range_sel] <= i_cfg_data[RANGE_W-1:0];
                end
                REG_TAIL_COLUMN: begin
                    r_cfg.tail_column <= i_cfg_data[TAIL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/cre_line_store.sv @@
module cre_line_store import cre_pkg::*; (
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] mem [LINE_CAPACITY];
    logic [CHAR_W-1:0] r_rdata;

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/cre_walker.sv @@
module cre_walker import cre_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    cre_in_if.sink            i_in,
    cre_out_if.source         o_out,
    output t_ram_req          o_req,
    input  logic [CHAR_W-1:0] i_rdata
);

    t_state r_state, n_state;

    logic [LEN_W-1:0]  r_len, n_len;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_hi, n_hi;
    logic              r_tail, n_tail;
    logic              r_ov, n_ov;
    logic [CHAR_W-1:0] r_ochar, n_ochar;
    logic              r_ocv, n_ocv;
    logic              r_olast, n_olast;

    logic [PCNT_W-1:0]  pairs_sat;
    logic [RANGE_W-1:0] rng;
    logic [COL_W-1:0]   col_a, col_b, lo, hi;
    logic [ADDR_W-1:0]  len_m1, hi_clip;
    logic               in_closed, closed_go, tail_go, span_end, out_free, in_beat;

    assign in_beat  = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;

    assign pairs_sat = (i_cfg.pair_count > PCNT_W'(MAX_PAIRS)) ? PCNT_W'(MAX_PAIRS)
                                                                : i_cfg.pair_count;
    assign in_closed = {1'b0, r_idx} < {1'b0, pairs_sat};
    assign rng       = (r_idx < IDX_W'(NUM_RANGES)) ? i_cfg.ranges[r_idx] : '0;
    assign col_a     = rng[COL_W-1:0];
    assign col_b     = rng[RANGE_W-1:COL_W];
    assign lo        = (col_a < col_b) ? col_a : col_b;
    assign hi        = (col_a < col_b) ? col_b : col_a;
    assign len_m1    = ADDR_W'(r_len - LEN_W'(1));
    assign hi_clip   = (LEN_W'(hi) >= r_len) ? len_m1 : ADDR_W'(hi);

    assign closed_go = (LEN_W'(lo) < r_len) && (r_n != CNT_W'(OUT_LIMIT));
    assign tail_go   = (i_cfg.tail_column < NO_TAIL) &&
                       (LEN_W'(i_cfg.tail_column) < r_len) &&
                       (r_n != CNT_W'(OUT_LIMIT));
    assign span_end  = (r_pos == r_hi) || (r_n == CNT_W'(OUT_LIMIT - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_beat && i_in.line_done) begin
                    n_state = ST_RANGE;
                end
            end
            ST_RANGE: begin
                if (in_closed) begin
                    n_state = closed_go ? ST_READ : ST_CLOSE;
                end else begin
                    n_state = tail_go ? ST_READ : ST_CLOSE;
                end
            end
            ST_READ: begin
                n_state = ST_DATA;
            end
            ST_DATA: begin
                if (out_free) begin
                    if (span_end) begin
                        n_state = r_tail ? ST_CLOSE : ST_RANGE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_CLOSE: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_len      = r_len;
        n_idx      = r_idx;
        n_n        = r_n;
        n_pos      = r_pos;
        n_hi       = r_hi;
        n_tail     = r_tail;
        n_ov       = r_ov && !o_out.ready;
        n_ochar    = r_ochar;
        n_ocv      = r_ocv;
        n_olast    = r_olast;
        o_req      = '0;
        i_in.ready = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                i_in.ready = 1'b1;
                if (in_beat) begin
                    if (!i_in.line_done) begin
                        if (r_len < LEN_W'(LINE_CAPACITY)) begin
                            o_req.we    = 1'b1;
                            o_req.waddr = r_len[ADDR_W-1:0];
                            o_req.wdata = i_in.in_char;
                            n_len       = r_len + LEN_W'(1);
                        end
                    end else begin
                        n_idx  = '0;
                        n_n    = '0;
                        n_tail = 1'b0;
                    end
                end
            end
            ST_RANGE: begin
                if (in_closed && closed_go) begin
                    n_pos = ADDR_W'(lo);
                    n_hi  = hi_clip;
                end else if (!in_closed && tail_go) begin
                    n_pos  = ADDR_W'(i_cfg.tail_column);
                    n_hi   = len_m1;
                    n_tail = 1'b1;
                end
            end
            ST_READ: begin
                o_req.re    = 1'b1;
                o_req.raddr = r_pos;
            end
            ST_DATA: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ochar = i_rdata;
                    n_ocv   = 1'b1;
                    n_olast = 1'b0;
                    n_pos   = r_pos + ADDR_W'(1);
                    n_n     = r_n + CNT_W'(1);
                    if (span_end && !r_tail) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_CLOSE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ochar = '0;
                    n_ocv   = 1'b0;
                    n_olast = 1'b1;
                    n_len   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_len   <= '0;
            r_idx   <= '0;
            r_n     <= '0;
            r_tail  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_n     <= n_n;
            r_tail  <= n_tail;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_hi    <= n_hi;
        r_ochar <= n_ochar;
        r_ocv   <= n_ocv;
        r_olast <= n_olast;
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_char   = r_ochar;
    assign o_out.char_valid = r_ocv;
    assign o_out.last       = r_olast;

endmodule

@@ hw/rtl/cre_checker.sv @@
module cre_checker import cre_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_line_done,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] i_out_char,
    input logic              i_char_valid,
    input logic              i_last
);

    logic [LEN_W-1:0] r_cnt;

    // characters emitted so far in the current output line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_cnt <= i_last ? '0 : r_cnt + LEN_W'(1);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char) &&
            $stable(i_char_valid) && $stable(i_last))
        else $error("output beat changed while stalled");

    a_close_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_char_valid != i_last) &&
            (i_char_valid || i_out_char == '0))
        else $error("malformed output beat");

    a_walk_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_line_done |=> !i_in_ready)
        else $error("input taken right after end of line");

    a_out_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_char_valid |-> r_cnt < LEN_W'(OUT_LIMIT))
        else $error("too many characters in one line");

endmodule

bind column_range_extractor cre_checker u_cre_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_line_done  (i_in.line_done),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_char   (o_out.out_char),
    .i_char_valid (o_out.char_valid),
    .i_last       (o_out.last)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import cre_pkg::*;

    // run bounds
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_GAP      = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 110;
    localparam int REPORT_LIMIT = 10;

    // one input beat: a character or an end-of-line marker
    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              line_done;
    } t_line_item;

    // one output beat of the cut line
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              last;
    } t_cut_beat;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    cre_in_if  in_bus ();
    cre_out_if out_bus ();

    column_range_extractor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    // shadow copy of the register file, updated as each write is driven
    logic [PCNT_W-1:0]  cfg_pairs = '0;
    logic [RANGE_W-1:0] cfg_range [NUM_RANGES] = '{default: '0};
    logic [TAIL_W-1:0]  cfg_tail  = NO_TAIL;

    // shadow copy of the line being gathered
    logic [CHAR_W-1:0] line_buf [LINE_CAPACITY];
    int                line_len = 0;

    t_line_item line_items_q [$];   // beats waiting to be sent
    t_cut_beat  cut_beats_q [$];    // beats the block still owes us

    bit burst_mode   = 1'b0;        // no idling on either side while set
    int items_queued = 0;
    int chars_loaded = 0;
    int lines_cut    = 0;
    int beats_seen   = 0;
    int mismatches   = 0;
    int settings     = 0;
    int cycle_count  = 0;

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // safety net against a hung handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed",
                     cycle_count, cut_beats_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // one column pair packed the way the range registers hold it
    function automatic logic [RANGE_W-1:0] col_pair(int a, int b);
        return RANGE_W'(a) | (RANGE_W'(b) << COL_W);
    endfunction

    // copy columns lo..hi of the line to the expected output, clipped at
    // the line end and stopped once the output is full
    function automatic int copy_columns(int n, int lo, int hi);
        int k;
        if (hi >= line_len)
            hi = line_len - 1;
        for (k = lo; k <= hi && n < OUT_LIMIT; k++) begin
            cut_beats_q.push_back(t_cut_beat'{out_char: line_buf[k], char_valid: 1'b1,
                                              last: 1'b0});
            n++;
        end
        return n;
    endfunction

    // end of line: walk the closed ranges, then the open tail range,
    // then the closing beat; the line starts over empty
    function automatic void cut_line();
        int  n;
        int  pairs;
        int  i;
        int  a;
        int  b;
        int  lo;
        int  hi;
        bit  stopped;
        n       = 0;
        stopped = 1'b0;
        pairs   = int'(cfg_pairs);
        if (pairs > MAX_PAIRS)
            pairs = MAX_PAIRS;
        if (pairs > NUM_RANGES)
            pairs = NUM_RANGES;
        for (i = 0; i < pairs && !stopped; i++) begin
            a  = int'(cfg_range[i][COL_W-1:0]);
            b  = int'(cfg_range[i][RANGE_W-1:COL_W]);
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            // a range starting at or past the line end, or a full output, ends the walk
            if (lo >= line_len || n >= OUT_LIMIT)
                stopped = 1'b1;
            else
                n = copy_columns(n, lo, hi);
        end
        // open range only if the walk got through every closed range
        if (!stopped && cfg_tail < NO_TAIL && int'(cfg_tail) < line_len && n < OUT_LIMIT)
            n = copy_columns(n, int'(cfg_tail), line_len - 1);
        cut_beats_q.push_back(t_cut_beat'{out_char: '0, char_valid: 1'b0, last: 1'b1});
        line_len = 0;
    endfunction

    // driver: sends queued beats, with a random pause after each one unless in burst mode
    int in_gap = 0;
    always @(posedge i_clk) begin : drive_line
        t_line_item nxt;
        if (!i_rst_n) begin
            in_bus.valid     <= 1'b0;
            in_bus.in_char   <= '0;
            in_bus.line_done <= 1'b0;
            in_gap = 0;
        end else begin
            // beat taken at this edge: update the prediction
            if (in_bus.valid && in_bus.ready) begin
                if (in_bus.line_done) begin
                    cut_line();
                    lines_cut++;
                end else begin
                    chars_loaded++;
                    // characters past the store capacity are dropped
                    if (line_len < LINE_CAPACITY) begin
                        line_buf[line_len] = in_bus.in_char;
                        line_len++;
                    end
                end
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_bus.valid <= 1'b0;
                end else if (line_items_q.size() > 0) begin
                    nxt = line_items_q.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.in_char   <= nxt.in_char;
                    in_bus.line_done <= nxt.line_done;
                    in_gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what, t_cut_beat want, t_cut_beat got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s at output beat %0d: expected char %02h valid %0b last %0b,",
                     what, beats_seen, want.out_char, want.char_valid, want.last);
            $display("    got char %02h valid %0b last %0b",
                     got.out_char, got.char_valid, got.last);
        end
    endtask

    // monitor: checks every output beat, stalls ready at random after each unless in burst mode
    int out_stall = 0;
    always @(posedge i_clk) begin : check_cut
        t_cut_beat got;
        t_cut_beat want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got = t_cut_beat'{out_char: out_bus.out_char, char_valid: out_bus.char_valid,
                                  last: out_bus.last};
                beats_seen++;
                if (cut_beats_q.size() == 0) begin
                    report_mismatch("unexpected beat", '0, got);
                end else begin
                    want = cut_beats_q.pop_front();
                    if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
                        got.last !== want.last)
                        report_mismatch("mismatch", want, got);
                end
                out_stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (out_stall > 0) begin
                out_stall--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    function automatic void push_item(logic [CHAR_W-1:0] c, logic done);
        line_items_q.push_back(t_line_item'{in_char: c, line_done: done});
        items_queued++;
    endfunction

    // a line of random characters, closed by an end-of-line beat with a
    // random (ignored) character
    function automatic void queue_line(int len);
        int k;
        for (k = 0; k < len; k++)
            push_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
        push_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endfunction

    // all sent, all accepted, nothing owed
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (line_items_q.size() != 0 || in_bus.valid || cut_beats_q.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    // write the whole register file back to back, then leave the port quiet
    task automatic load_regs(int pairs, logic [NUM_RANGES-1:0][RANGE_W-1:0] ranges, int tail);
        int i;
        write_reg(REG_PAIR_COUNT, CFG_DATA_W'(pairs));
        cfg_pairs = PCNT_W'(pairs);
        for (i = 0; i < NUM_RANGES; i++) begin
            write_reg(REG_RANGE_0 + CFG_IDX_W'(i), ranges[i]);
            cfg_range[i] = ranges[i];
        end
        write_reg(REG_TAIL_COLUMN, CFG_DATA_W'(tail));
        cfg_tail = TAIL_W'(tail);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [NUM_RANGES-1:0][RANGE_W-1:0] ranges;
        int budget;
        int rnd_phase;
        int lines;
        int len;
        int tail;
        int k;

        in_bus.valid     = 1'b0;
        in_bus.in_char   = '0;
        in_bus.line_done = 1'b0;
        out_bus.ready    = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults: no ranges, no tail, so only closing beats
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'h5A, 1'b1);
        // empty line
        push_item(8'hA5, 1'b1);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // reversed ends, a range clipped at the line end, then a range past
        // the end that stops the walk before the tail
        ranges    = '0;
        ranges[0] = col_pair(2, 0);
        ranges[1] = col_pair(1, 40);
        ranges[2] = col_pair(50, 55);
        load_regs(3, ranges, 1);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        for (k = 0; k < 6; k++)
            push_item(CHAR_W'(8'h41 + k), 1'b0);
        push_item(8'h00, 1'b1);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // open tail range alone
        ranges = '0;
        load_regs(0, ranges, 3);
        for (k = 0; k < 6; k++)
            push_item(CHAR_W'(8'h30 + k), 1'b0);
        push_item(8'hFF, 1'b1);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // pair count above the maximum saturates; sixth range starts at the
        // line end so the tail is never walked
        for (k = 0; k < NUM_RANGES; k++)
            ranges[k] = col_pair(k, k);
        load_regs(7, ranges, 0);
        for (k = 0; k < 5; k++)
            push_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
        push_item(8'h00, 1'b1);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // random part: one register setting per phase, a few lines each
        budget    = items_queued + RANDOM_ITEMS;
        rnd_phase = 0;
        while (items_queued < budget) begin
            ranges = '0;
            if (rnd_phase == 0) begin
                // whole line twice plus tail from column 0: output fills up
                ranges[0] = col_pair(0, 63);
                ranges[1] = col_pair(63, 0);
                tail      = 0;
                load_regs(2, ranges, tail);
            end else if (rnd_phase == 1) begin
                // every register at its top value
                for (k = 0; k < NUM_RANGES; k++)
                    ranges[k] = '1;
                load_regs(7, ranges, 127);
            end else begin
                for (k = 0; k < NUM_RANGES; k++)
                    if ($urandom_range(0, 3) == 0)
                        ranges[k] = RANGE_W'($urandom_range(0, 4095));
                    else
                        ranges[k] = col_pair($urandom_range(0, 20), $urandom_range(0, 20));
                case ($urandom_range(0, 3))
                    0:       tail = $urandom_range(0, 20);
                    1:       tail = 63;
                    2:       tail = 64;
                    default: tail = $urandom_range(65, 127);
                endcase
                load_regs($urandom_range(0, 7), ranges, tail);
            end
            burst_mode = (rnd_phase % 3 == 2);
            lines = $urandom_range(1, 3);
            for (k = 0; k < lines; k++) begin
                // before the second line, hold the sender back until the first is fully out
                if (k == 1)
                    wait_idle();
                if (rnd_phase == 0 && k == 0)
                    len = 70;
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(30, 66);
                else
                    len = $urandom_range(0, 16);
                queue_line(len);
            end
            wait_idle();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            rnd_phase++;
        end

        wait_idle();
        burst_mode = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (cut_beats_q.size() != 0)
            $display("%0d expected beats never arrived", cut_beats_q.size());
        $display("%0d lines cut under %0d register settings, %0d characters loaded",
                 lines_cut, settings, chars_loaded);
        $display("%0d output beats checked, %0d mismatches", beats_seen, mismatches);
        if (mismatches == 0 && cut_beats_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
